>>> sv/sbo_pkg.sv
// Shared types and constants for the segment box occlusion gain block.
package sbo_pkg;

  localparam int GAIN_W = 17;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;
  localparam int GAIN_FRAC = 16;
  localparam int DIGIT_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HF_FLOOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKED  = 2'd2;

  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_BOX   = 1'b1;

  typedef enum logic [2:0] {
    TS_IDLE, TS_START, TS_WAIT, TS_VIS, TS_GAIN
  } top_state_t;

  typedef enum logic [1:0] {
    MS_IDLE, MS_ISSUE, MS_WAIT, MS_DONE
  } merge_state_t;

  typedef enum logic [1:0] {
    ST_LO, ST_HI, ST_FIN
  } step_t;

  typedef struct packed {
    logic done;
    logic pos;
    logic neg;
  } cmp_res_t;

  typedef struct packed {
    logic zero;
    logic outside;
  } lane_flags_t;

  function automatic logic [GAIN_W-1:0] sat_one(input logic [GAIN_W-1:0] v);
    return (v > GAIN_ONE) ? GAIN_ONE : v;
  endfunction

endpackage

>>> sv/sbo_lane.sv
// One axis lane: slab numerators, delta magnitude and degenerate-axis flags.
module sbo_lane #(
  parameter int W = 32
) (
  input  logic                   clk,
  input  logic                   load,
  input  logic signed [W-1:0]    o,
  input  logic signed [W-1:0]    e,
  input  logic signed [W-1:0]    mn,
  input  logic signed [W-1:0]    mx,
  output logic signed [W:0]      n0,
  output logic signed [W:0]      n1,
  output logic        [W-1:0]    d,
  output sbo_pkg::lane_flags_t   flags
);

  logic signed [W:0] dl, a0, a1, b0, b1, dm;

  always_comb begin
    dl = (W+1)'(e) - (W+1)'(o);
    a0 = (W+1)'(mn) - (W+1)'(o);
    a1 = (W+1)'(mx) - (W+1)'(o);
    if (dl < 0) begin
      a0 = -a0;
      a1 = -a1;
      dm = -dl;
    end else begin
      dm = dl;
    end
    if (a0 > a1) begin
      b0 = a1;
      b1 = a0;
    end else begin
      b0 = a0;
      b1 = a1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      n0 <= b0;
      n1 <= b1;
      d <= dm[W-1:0];
      flags.zero <= (dl == 0);
      flags.outside <= (o < mn) || (o > mx);
    end
  end

endmodule

>>> sv/sbo_fcmp.sv
// Multi-cycle exact fraction compare: sign of an*bd - bn*ad, one digit product a cycle.
module sbo_fcmp #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [W:0]    an,
  input  logic        [W-1:0]  ad,
  input  logic signed [W:0]    bn,
  input  logic        [W-1:0]  bd,
  output sbo_pkg::cmp_res_t    res
);

  localparam int NW = W + 1;
  localparam int DIG = sbo_pkg::DIGIT_W;
  localparam int ND = (W + DIG - 1) / DIG;
  localparam int PW = ND * DIG;
  localparam int AW = 2 * W + 2;
  localparam int CW = (ND > 1) ? $clog2(ND) : 1;
  localparam int PRW = NW + DIG + 1;

  logic                 busy;
  logic                 half;
  logic [CW-1:0]        cnt;
  logic signed [AW-1:0] acc;
  logic signed [NW-1:0] xa, xb;
  logic [PW-1:0]        ya, yb;
  logic signed [NW-1:0] mc;
  logic [DIG-1:0]       dg;
  logic signed [PRW-1:0] part;
  logic signed [AW-1:0] partx, acc_next;

  always_comb begin
    mc = half ? xb : xa;
    dg = half ? yb[cnt*DIG +: DIG] : ya[cnt*DIG +: DIG];
    part = PRW'(mc) * $signed({1'b0, dg});
    partx = AW'(part);
    acc_next = half ? (acc - partx) : ((acc <<< DIG) + partx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      res <= '0;
    end else begin
      res.done <= busy && !start && half && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        half <= 1'b0;
        cnt <= CW'(ND - 1);
        acc <= '0;
        xa <= an;
        xb <= bn;
        ya <= PW'(bd);
        yb <= PW'(ad);
      end else if (busy) begin
        acc <= acc_next;
        half <= ~half;
        if (half) begin
          if (cnt == '0) begin
            busy <= 1'b0;
            res.pos <= (acc_next > 0);
            res.neg <= (acc_next < 0);
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
      end
    end
  end

endmodule

>>> sv/sbo_merge.sv
// Merge stage: walks the axis lanes and narrows the [lo, hi] interval to decide a hit.
module sbo_merge #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [W:0]     n0 [3],
  input  logic signed [W:0]     n1 [3],
  input  logic        [W-1:0]   d [3],
  input  sbo_pkg::lane_flags_t  flags [3],
  output logic                  done,
  output logic                  hit
);

  sbo_pkg::merge_state_t state, state_next;
  sbo_pkg::step_t        step;
  sbo_pkg::cmp_res_t     res;
  logic [1:0]            ax;
  logic                  miss;
  logic                  cmp_start;
  logic signed [W:0]     lo_n, hi_n, an, bn;
  logic [W-1:0]          lo_d, hi_d, ad, bd;
  logic                  skip;

  always_comb begin
    skip = (step != sbo_pkg::ST_FIN) && flags[ax].zero;
    unique case (step)
      sbo_pkg::ST_LO: begin
        an = n0[ax]; ad = d[ax]; bn = lo_n; bd = lo_d;
      end
      sbo_pkg::ST_HI: begin
        an = n1[ax]; ad = d[ax]; bn = hi_n; bd = hi_d;
      end
      default: begin
        an = lo_n; ad = lo_d; bn = hi_n; bd = hi_d;
      end
    endcase
  end

  sbo_fcmp #(.W(W)) u_fcmp (
    .clk(clk), .rst(rst), .start(cmp_start),
    .an(an), .ad(ad), .bn(bn), .bd(bd), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= sbo_pkg::MS_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmp_start = 1'b0;
    done = 1'b0;
    unique case (state)
      sbo_pkg::MS_IDLE: begin
        if (start) state_next = sbo_pkg::MS_ISSUE;
      end
      sbo_pkg::MS_ISSUE: begin
        if (!skip) begin
          cmp_start = 1'b1;
          state_next = sbo_pkg::MS_WAIT;
        end
      end
      sbo_pkg::MS_WAIT: begin
        if (res.done) begin
          state_next = (step == sbo_pkg::ST_FIN) ? sbo_pkg::MS_DONE : sbo_pkg::MS_ISSUE;
        end
      end
      sbo_pkg::MS_DONE: begin
        done = 1'b1;
        state_next = sbo_pkg::MS_IDLE;
      end
      default: state_next = sbo_pkg::MS_IDLE;
    endcase
  end

  assign hit = ~miss;

  always_ff @(posedge clk) begin
    if (state == sbo_pkg::MS_IDLE && start) begin
      lo_n <= '0;
      lo_d <= W'(1);
      hi_n <= (W+1)'(1);
      hi_d <= W'(1);
      ax <= 2'd0;
      step <= sbo_pkg::ST_LO;
      miss <= (flags[0].zero && flags[0].outside) || (flags[1].zero && flags[1].outside)
           || (flags[2].zero && flags[2].outside);
    end else if (state == sbo_pkg::MS_ISSUE && skip) begin
      if (ax == 2'd2) step <= sbo_pkg::ST_FIN;
      else ax <= ax + 2'd1;
    end else if (state == sbo_pkg::MS_WAIT && res.done) begin
      unique case (step)
        sbo_pkg::ST_LO: begin
          if (res.pos) begin
            lo_n <= n0[ax];
            lo_d <= d[ax];
          end
          step <= sbo_pkg::ST_HI;
        end
        sbo_pkg::ST_HI: begin
          if (res.neg) begin
            hi_n <= n1[ax];
            hi_d <= d[ax];
          end
          if (ax == 2'd2) begin
            step <= sbo_pkg::ST_FIN;
          end else begin
            step <= sbo_pkg::ST_LO;
            ax <= ax + 2'd1;
          end
        end
        default: begin
          if (res.pos) miss <= 1'b1;
        end
      endcase
    end
  end

endmodule

>>> sv/segment_box_occlusion_gain.sv
// Top level of the segment box occlusion gain block.
// Usage: a request on the s_ channel with tuser = 0 begins a query (listener in the
// a fields, source in the b fields, prior visibility); requests with tuser = 1 each carry
// one blocker box (min corner in a, max corner in b). tlast ends the query, and one
// result (visibility, gain, hf_gain) leaves on the m_ channel.
// Throughput: one request at a time. A box request with tests on is accepted, then
// starts the merge stage, which runs up to 7 exact fraction compares of ND digits each
// with ND = ceil(COORD_WIDTH/16), and then returns the hit; an axis with zero delta
// skips its two compares. All compares share one compare unit. A request with tlast
// then computes the visibility product, then the gain products, before the result
// register loads. Reset clears the query state and the configuration registers and
// empties the output. When the receiver stalls, the result waits in the output
// register; the next request is still taken, and only a further result waits until the
// register frees. Configuration writes go through cfg_wen/cfg_index/cfg_data; the user
// must make them only while the block is idle, which the block does not enforce.
module segment_box_occlusion_gain #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, source_visibility, zero pad
  input  logic [((6*COORD_WIDTH+17+7)/8)*8-1:0] s_tdata,
  // cmd
  input  logic [0:0] s_tuser,
  input  logic s_tlast,
  output logic m_tvalid,
  input  logic m_tready,
  // visibility, gain, hf_gain, zero pad
  output logic [55:0] m_tdata,
  input  logic cfg_wen,
  input  logic [sbo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbo_pkg::GAIN_W-1:0] cfg_data
);

  localparam int W = COORD_WIDTH;
  localparam int GW = sbo_pkg::GAIN_W;
  localparam int FB = FRAC_BITS;

  logic [GW-1:0] gain_floor, hf_gain_floor, box_vis_factor;
  logic signed [W-1:0] seg_start [3];
  logic signed [W-1:0] seg_end [3];
  logic signed [W-1:0] fa [3];
  logic signed [W-1:0] fb [3];
  logic [GW-1:0] held_visibility, vis, src_vis;
  logic tests_enabled, any_box_hit, last_q;
  logic accept, is_box, same_pt;
  logic mrg_start, mrg_done, mrg_hit, out_load;
  sbo_pkg::top_state_t state, state_next;

  logic signed [W:0] n0 [3];
  logic signed [W:0] n1 [3];
  logic [W-1:0] d [3];
  sbo_pkg::lane_flags_t flags [3];

  logic [2*GW-1:0] vprod, gprod, hprod;
  logic [GW-1:0] gain_v, hf_v;

  assign accept = s_tvalid && s_tready;
  assign is_box = (s_tuser[0] == sbo_pkg::CMD_BOX);
  assign src_vis = s_tdata[6*W +: GW];

  always_comb begin
    same_pt = 1'b1;
    for (int i = 0; i < 3; i++) begin
      fa[i] = s_tdata[i*W +: W];
      fb[i] = s_tdata[(i+3)*W +: W];
      if (fa[i] != fb[i]) same_pt = 1'b0;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    sbo_lane #(.W(W)) u_lane (
      .clk(clk), .load(accept && is_box),
      .o(seg_start[g]), .e(seg_end[g]), .mn(fa[g]), .mx(fb[g]),
      .n0(n0[g]), .n1(n1[g]), .d(d[g]), .flags(flags[g])
    );
  end

  sbo_merge #(.W(W)) u_merge (
    .clk(clk), .rst(rst), .start(mrg_start),
    .n0(n0), .n1(n1), .d(d), .flags(flags),
    .done(mrg_done), .hit(mrg_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_floor <= '0;
      hf_gain_floor <= '0;
      box_vis_factor <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        sbo_pkg::REG_MIN_GAIN: gain_floor <= cfg_data;
        sbo_pkg::REG_HF_FLOOR: hf_gain_floor <= cfg_data;
        sbo_pkg::REG_BLOCKED:  box_vis_factor <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= sbo_pkg::TS_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    s_tready = 1'b0;
    mrg_start = 1'b0;
    out_load = 1'b0;
    unique case (state)
      sbo_pkg::TS_IDLE: begin
        s_tready = 1'b1;
        if (accept) begin
          if (is_box && tests_enabled) state_next = sbo_pkg::TS_START;
          else if (s_tlast) state_next = sbo_pkg::TS_VIS;
        end
      end
      sbo_pkg::TS_START: begin
        mrg_start = 1'b1;
        state_next = sbo_pkg::TS_WAIT;
      end
      sbo_pkg::TS_WAIT: begin
        if (mrg_done) state_next = last_q ? sbo_pkg::TS_VIS : sbo_pkg::TS_IDLE;
      end
      sbo_pkg::TS_VIS: begin
        state_next = sbo_pkg::TS_GAIN;
      end
      sbo_pkg::TS_GAIN: begin
        if (!m_tvalid || m_tready) begin
          out_load = 1'b1;
          state_next = sbo_pkg::TS_IDLE;
        end
      end
      default: state_next = sbo_pkg::TS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        seg_start[i] <= '0;
        seg_end[i] <= '0;
      end
      held_visibility <= '0;
      tests_enabled <= 1'b0;
      any_box_hit <= 1'b0;
      last_q <= 1'b0;
    end else begin
      if (accept) begin
        last_q <= s_tlast;
        if (!is_box) begin
          for (int i = 0; i < 3; i++) begin
            seg_start[i] <= fa[i];
            seg_end[i] <= fb[i];
          end
          held_visibility <= sbo_pkg::sat_one(src_vis);
          tests_enabled <= (sbo_pkg::sat_one(src_vis) != '0) && !same_pt;
          any_box_hit <= 1'b0;
        end
      end
      if (state == sbo_pkg::TS_WAIT && mrg_done && mrg_hit) any_box_hit <= 1'b1;
    end
  end

  assign vprod = held_visibility * sbo_pkg::sat_one(box_vis_factor);

  always_ff @(posedge clk) begin
    if (state == sbo_pkg::TS_VIS) begin
      vis <= any_box_hit ? vprod[sbo_pkg::GAIN_FRAC +: GW] : held_visibility;
    end
  end

  assign gprod = (sbo_pkg::GAIN_ONE - sbo_pkg::sat_one(gain_floor)) * vis;
  assign hprod = (sbo_pkg::GAIN_ONE - sbo_pkg::sat_one(hf_gain_floor)) * vis;

  always_comb begin
    if (vis >= sbo_pkg::GAIN_ONE) begin
      gain_v = sbo_pkg::GAIN_ONE;
      hf_v = sbo_pkg::GAIN_ONE;
    end else begin
      gain_v = sbo_pkg::sat_one(gain_floor) + gprod[sbo_pkg::GAIN_FRAC +: GW];
      hf_v = sbo_pkg::sat_one(hf_gain_floor) + hprod[sbo_pkg::GAIN_FRAC +: GW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {5'd0, hf_v, gain_v, vis};
    end
  end

  // FRAC_BITS scales coordinates uniformly; the slab test result does not depend on it.
  logic frac_ok;
  assign frac_ok = (FB >= 0);

  a_merge_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mrg_done |-> (state == sbo_pkg::TS_WAIT))
    else $error("merge finished outside of a box test");

  a_tests_need_vis: assert property (@(posedge clk) disable iff (rst)
    tests_enabled |-> (held_visibility != '0) && frac_ok)
    else $error("box tests enabled with zero visibility");

  a_gain_holds: assert property (@(posedge clk) disable iff (rst)
    (state == sbo_pkg::TS_GAIN) && m_tvalid && !m_tready |=> (state == sbo_pkg::TS_GAIN))
    else $error("result overwrote a pending output");

endmodule
